/* rtl/core/csin_pkg.sv */
package csin_pkg;

  localparam int unsigned ITERATIONS = 20;
  localparam int unsigned AmpW       = 16;
  localparam int unsigned PhW        = 24;
  localparam int unsigned ResW       = 22;   // residual angle bits
  localparam int unsigned VecW       = 26;   // cosine / sine datapath
  localparam int unsigned AngW       = 25;   // signed angle datapath
  localparam int unsigned RW         = 28;   // scaled sine
  localparam int unsigned SmpW       = 16;
  localparam int unsigned ShW        = 5;
  localparam int unsigned NumStg     = ITERATIONS + 3;

  // quadrant codes, phase bits 23..22
  localparam logic [1:0] QuadI   = 2'd0;
  localparam logic [1:0] QuadII  = 2'd1;
  localparam logic [1:0] QuadIII = 2'd2;
  localparam logic [1:0] QuadIV  = 2'd3;

  localparam logic signed [RW-1:0] SatPos = RW'(8388608);
  localparam logic signed [RW-1:0] SatNeg = -SatPos;
  localparam logic [SmpW-1:0] SmpMax = 16'h7fff;
  localparam logic [SmpW-1:0] SmpMin = 16'h8001;

  typedef struct packed {
    logic signed [VecW-1:0] s;
    logic signed [VecW-1:0] c;
    logic signed [AngW-1:0] z;
  } vec_t;

  // atan(2^-i) in phase units, a full turn is 2^24
  function automatic logic signed [AngW-1:0] angle_step(input logic [ShW-1:0] idx);
    logic signed [AngW-1:0] r;
    unique case (idx)
      5'd0:    r = AngW'(2097152);
      5'd1:    r = AngW'(1238021);
      5'd2:    r = AngW'(654136);
      5'd3:    r = AngW'(332050);
      5'd4:    r = AngW'(166669);
      5'd5:    r = AngW'(83416);
      5'd6:    r = AngW'(41718);
      5'd7:    r = AngW'(20860);
      5'd8:    r = AngW'(10430);
      5'd9:    r = AngW'(5215);
      5'd10:   r = AngW'(2608);
      5'd11:   r = AngW'(1304);
      5'd12:   r = AngW'(652);
      5'd13:   r = AngW'(326);
      5'd14:   r = AngW'(163);
      5'd15:   r = AngW'(81);
      5'd16:   r = AngW'(41);
      5'd17:   r = AngW'(20);
      5'd18:   r = AngW'(10);
      5'd19:   r = AngW'(5);
      5'd20:   r = AngW'(3);
      5'd21:   r = AngW'(1);
      5'd22:   r = AngW'(1);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

/* rtl/core/csin_prerot.sv */
module csin_prerot (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [csin_pkg::AmpW-1:0]     amplitude_i,
  input  logic [csin_pkg::PhW-1:0]      phase_i,
  output csin_pkg::vec_t                q_o
);

  logic [csin_pkg::ResW-1:0]        a;
  logic signed [csin_pkg::VecW-1:0] a_ext;
  csin_pkg::vec_t                   d;
  csin_pkg::vec_t                   vec_q;

  // widen the amplitude, low bits refilled from its top bits
  assign a     = {amplitude_i, 6'b0} | csin_pkg::ResW'(amplitude_i >> 10);
  assign a_ext = $signed({{(csin_pkg::VecW - csin_pkg::ResW){1'b0}}, a});

  always_comb begin
    d.s = '0;
    d.c = '0;
    d.z = $signed({{(csin_pkg::AngW - csin_pkg::ResW){1'b0}},
                   phase_i[csin_pkg::ResW-1:0]});
    unique case (phase_i[csin_pkg::PhW-1 -: 2])
      csin_pkg::QuadI:   d.c = a_ext;
      csin_pkg::QuadII:  d.s = a_ext;
      csin_pkg::QuadIII: d.c = -a_ext;
      csin_pkg::QuadIV:  d.s = -a_ext;
      default:           d.c = a_ext;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      vec_q <= d;
    end
  end

  assign q_o = vec_q;

endmodule

/* rtl/core/csin_cell.sv */
module csin_cell (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [csin_pkg::ShW-1:0]  shift_i,
  input  csin_pkg::vec_t            d_i,
  output csin_pkg::vec_t            q_o
);

  logic signed [csin_pkg::VecW-1:0] s_in, c_in, s_sh, c_sh;
  logic signed [csin_pkg::AngW-1:0] z_in, ang;
  csin_pkg::vec_t                   vec_d, vec_q;

  assign s_in = d_i.s;
  assign c_in = d_i.c;
  assign z_in = d_i.z;
  assign s_sh = s_in >>> shift_i;
  assign c_sh = c_in >>> shift_i;
  assign ang  = csin_pkg::angle_step(shift_i);

  // rotate toward zero residual angle
  always_comb begin
    if (!z_in[csin_pkg::AngW-1]) begin
      vec_d.s = s_in + c_sh;
      vec_d.c = c_in - s_sh;
      vec_d.z = z_in - ang;
    end else begin
      vec_d.s = s_in - c_sh;
      vec_d.c = c_in + s_sh;
      vec_d.z = z_in + ang;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      vec_q <= vec_d;
    end
  end

  assign q_o = vec_q;

endmodule

/* rtl/core/csin_post.sv */
module csin_post (
  input  logic                        clk_i,
  input  logic                        en_scale_i,
  input  logic                        en_out_i,
  input  csin_pkg::vec_t              d_i,
  output logic [csin_pkg::SmpW-1:0]   sample_o
);

  logic signed [csin_pkg::RW-1:0] s_ext, r_d, r_q;
  logic [csin_pkg::SmpW-1:0]      smp_d, smp_q;

  assign s_ext = csin_pkg::RW'(d_i.s);
  // gain of 1 + 1/8 + 1/16 + 1/64 + 1/128
  assign r_d = s_ext + (s_ext >>> 3) + (s_ext >>> 4) + (s_ext >>> 6) + (s_ext >>> 7);

  always_comb begin
    priority if (r_q <= csin_pkg::SatNeg) begin
      smp_d = csin_pkg::SmpMin;
    end else if (r_q >= csin_pkg::SatPos) begin
      smp_d = csin_pkg::SmpMax;
    end else begin
      smp_d = r_q[8 +: csin_pkg::SmpW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_scale_i) begin
      r_q <= r_d;
    end
    if (en_out_i) begin
      smp_q <= smp_d;
    end
  end

  assign sample_o = smp_q;

endmodule

/* rtl/core/cordic_sine_sample.sv */
// cordic sine sample generator
// input channel s_axis: one beat carries amplitude (unsigned, 16 bits) and
//   phase (24 bits, a full turn is 2^24, top two bits pick the quadrant)
// output channel m_axis: one beat carries the signed 16-bit sine sample,
//   saturated to +/-32767 when the scaled result overflows
// structure: a quadrant pre-rotation stage, a row of 20 identical cordic
//   cells (one micro-rotation each, shift and angle fixed per cell), a gain
//   stage and a saturating output register
// throughput: one beat per clock while the output beat is taken; every
//   stage takes a new item each cycle that it is not stalled
// path: from input beat to output valid through 1 pre-rotation stage,
//   20 cells, 1 gain stage and 1 output register
// stall: each stage keeps its own valid bit and moves on when the stage
//   after it is empty or moving, so bubbles get squeezed out; s_axis_tready
//   only drops once every stage is full and the output beat is not taken
// reset: all valid bits clear, no output beat until new input arrives;
//   data registers are not reset
module cordic_sine_sample (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // [15:0] amplitude, [39:16] phase
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // [15:0] sample
);

  localparam int unsigned N = csin_pkg::ITERATIONS;
  localparam int unsigned S = csin_pkg::NumStg;

  logic [S-1:0]   vld_q, vld_d;
  logic [S-1:0]   en;
  csin_pkg::vec_t vec [0:N];

  // per-stage advance, rippling back from the output
  assign en[S-1] = !vld_q[S-1] || m_axis_tready;
  for (genvar k = 0; k < S - 1; k++) begin : g_en
    assign en[k] = !vld_q[k] || en[k+1];
  end

  assign vld_d[0] = en[0] ? s_axis_tvalid : vld_q[0];
  for (genvar k = 1; k < S; k++) begin : g_vld
    assign vld_d[k] = en[k] ? vld_q[k-1] : vld_q[k];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  csin_prerot u_prerot (
    .clk_i       (clk_i),
    .en_i        (en[0]),
    .amplitude_i (s_axis_tdata[15:0]),
    .phase_i     (s_axis_tdata[39:16]),
    .q_o         (vec[0])
  );

  // one cell per micro-rotation
  for (genvar i = 0; i < N; i++) begin : g_cell
    csin_cell u_cell (
      .clk_i   (clk_i),
      .en_i    (en[i+1]),
      .shift_i (csin_pkg::ShW'(i)),
      .d_i     (vec[i]),
      .q_o     (vec[i+1])
    );
  end

  csin_post u_post (
    .clk_i      (clk_i),
    .en_scale_i (en[S-2]),
    .en_out_i   (en[S-1]),
    .d_i        (vec[N]),
    .sample_o   (m_axis_tdata)
  );

  assign s_axis_tready = en[0];
  assign m_axis_tvalid = vld_q[S-1];

endmodule

/* rtl/core/csin_checker.sv */
module csin_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);

  // a stalled output beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output beat dropped or changed while stalled");

  // input backpressure only comes from a stalled output
  a_bp_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without output stall");

  // a taking receiver never blocks the input
  a_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready |-> s_axis_tready)
    else $error("input not ready while output is taken");

  // pipeline comes out of reset empty
  a_rst_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !m_axis_tvalid)
    else $error("output valid right after reset");

  // a valid output beat carries known data
  a_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !$isunknown(m_axis_tdata))
    else $error("output beat with unknown data");

endmodule

bind cordic_sine_sample csin_checker u_csin_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
